FILE: src/vn2d_pkg.sv
// Package with shared constants for the 2-D vector normalizer.
`timescale 1ns / 1ps

package vn2d_pkg;

    localparam int Q_BITS = 16;
    localparam int FRAC_SHIFT = 2 * Q_BITS;
    localparam logic [Q_BITS-1:0] Q_POS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};

    typedef logic [Q_BITS-1:0] t_q;

endpackage

FILE: src/vector_normalize_2d.sv
// Top level of the pipelined 2-D vector normalizer.
`timescale 1ns / 1ps

// Scales a signed integer vector (x, y) to unit length and returns both
// components as signed Q1.15 fractions, rounded to nearest with ties away
// from zero; +1.0 saturates to 32767 and -1.0 is -32768.
// The input word arrives on the s_axis channel and the result leaves on
// the m_axis channel, with a zero-vector flag on m_axis_tuser. A zero
// vector gives a zero result with the flag set.
// An accepted word passes, in order, through one stage for magnitudes
// and squares, one for the sum of squares and the search start values,
// sixteen stages that each settle one result bit per component by a
// shift-and-add compare, and the output register that drives m_axis.
// Throughput is one word per cycle while the output is not stalled.
// When the receiver holds m_axis_tready low while a result waits, the
// whole pipeline holds and s_axis_tready goes low; nothing is lost or
// repeated. Reset clears all valid bits, so the pipeline comes up empty.
module vector_normalize_2d #(
    parameter int IN_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: x_comp, y_comp, zero fill.
    input  logic [((2*IN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: unit_x, unit_y.
    output logic [2*vn2d_pkg::Q_BITS-1:0] m_axis_tdata,
    // Fields from bit 0: was_zero.
    output logic                   m_axis_tuser
);
    import vn2d_pkg::*;

    localparam int AW = 2 * IN_WIDTH + 38;
    localparam int SW = 2 * IN_WIDTH;

    logic w_en;

    logic            r_a_vld;
    logic [IN_WIDTH-1:0] r_a_mag [0:1];
    logic            r_a_neg [0:1];
    logic [SW-1:0]   r_a_sq  [0:1];

    logic                 r_vld  [0:Q_BITS];
    logic signed [AW-1:0] r_d    [0:Q_BITS][0:1];
    logic signed [AW-1:0] r_l    [0:Q_BITS][0:1];
    t_q                   r_q    [0:Q_BITS][0:1];
    logic                 r_neg  [0:Q_BITS][0:1];
    logic signed [AW-1:0] r_s    [0:Q_BITS];
    logic                 r_zero [0:Q_BITS];

    logic signed [AW-1:0] n_d [1:Q_BITS][0:1];
    logic signed [AW-1:0] n_l [1:Q_BITS][0:1];
    t_q                   n_q [1:Q_BITS][0:1];

    logic signed [AW-1:0] n_s0;
    logic signed [AW-1:0] n_d0 [0:1];

    logic            r_o_vld;
    t_q              r_o_unit [0:1];
    logic            r_o_zero;
    t_q              n_unit [0:1];

    logic [IN_WIDTH-1:0] w_raw [0:1];
    logic [IN_WIDTH-1:0] n_mag [0:1];

    assign w_en = !r_o_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    assign w_raw[0] = s_axis_tdata[IN_WIDTH-1:0];
    assign w_raw[1] = s_axis_tdata[2*IN_WIDTH-1:IN_WIDTH];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_mag[c] = w_raw[c][IN_WIDTH-1] ? (~w_raw[c] + 1'b1) : w_raw[c];
        end
        n_s0 = AW'(r_a_sq[0]) + AW'(r_a_sq[1]);
        for (int c = 0; c < 2; c++) begin
            n_d0[c] = (AW'(r_a_sq[c]) <<< FRAC_SHIFT) - n_s0;
        end
    end

    always_comb begin
        logic signed [AW-1:0] cand;
        for (int j = 0; j < Q_BITS; j++) begin
            for (int c = 0; c < 2; c++) begin
                cand = r_d[j][c] - (r_l[j][c] <<< (Q_BITS - j + 1))
                     - (r_s[j] <<< (2 * (Q_BITS - 1 - j) + 2));
                if (cand >= 0) begin
                    n_d[j+1][c] = cand;
                    n_l[j+1][c] = r_l[j][c] + (r_s[j] <<< (Q_BITS - j));
                    n_q[j+1][c] = r_q[j][c] | (t_q'(1) << (Q_BITS - 1 - j));
                end else begin
                    n_d[j+1][c] = r_d[j][c];
                    n_l[j+1][c] = r_l[j][c];
                    n_q[j+1][c] = r_q[j][c];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            if (r_zero[Q_BITS]) begin
                n_unit[c] = '0;
            end else if (r_neg[Q_BITS][c]) begin
                n_unit[c] = ~r_q[Q_BITS][c] + 1'b1;
            end else if (r_q[Q_BITS][c] > Q_POS_MAX) begin
                n_unit[c] = Q_POS_MAX;
            end else begin
                n_unit[c] = r_q[Q_BITS][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            for (int j = 0; j <= Q_BITS; j++) begin
                r_vld[j] <= 1'b0;
            end
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld  <= s_axis_tvalid;
            r_vld[0] <= r_a_vld;
            for (int j = 1; j <= Q_BITS; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
            r_o_vld <= r_vld[Q_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 2; c++) begin
                r_a_mag[c] <= n_mag[c];
                r_a_neg[c] <= w_raw[c][IN_WIDTH-1];
                r_a_sq[c]  <= n_mag[c] * n_mag[c];
                r_d[0][c]   <= n_d0[c];
                r_l[0][c]   <= -n_s0;
                r_q[0][c]   <= '0;
                r_neg[0][c] <= r_a_neg[c];
            end
            r_s[0]    <= n_s0;
            r_zero[0] <= (r_a_mag[0] == '0) && (r_a_mag[1] == '0);
            for (int j = 1; j <= Q_BITS; j++) begin
                for (int c = 0; c < 2; c++) begin
                    r_d[j][c]   <= n_d[j][c];
                    r_l[j][c]   <= n_l[j][c];
                    r_q[j][c]   <= n_q[j][c];
                    r_neg[j][c] <= r_neg[j-1][c];
                end
                r_s[j]    <= r_s[j-1];
                r_zero[j] <= r_zero[j-1];
            end
            r_o_unit[0] <= n_unit[0];
            r_o_unit[1] <= n_unit[1];
            r_o_zero    <= r_zero[Q_BITS];
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {r_o_unit[1], r_o_unit[0]};
    assign m_axis_tuser  = r_o_zero;

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("Zero vector flagged with a nonzero result.");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> r_o_vld == $past(r_vld[Q_BITS]))
        else $error("Result valid did not follow the last search stage.");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld[0] == $past(r_vld[0]) && r_a_vld == $past(r_a_vld))
        else $error("Pipeline moved while the output was stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("Output valid right after reset.");

endmodule
